// File: sv/fermat_factor_split_defines.svh
// Assertion helpers used by the RTL controller.
`ifndef FERMAT_FACTOR_SPLIT_DEFINES_SVH
`define FERMAT_FACTOR_SPLIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FFS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ffs_pkg.sv
package ffs_pkg;

    localparam int NUM_W   = 32;  // input number
    localparam int LARGE_W = 31;  // larger factor
    localparam int SMALL_W = 30;  // smaller factor
    localparam int DIV_W   = 31;  // positive dividend, sign bit dropped
    localparam int ROOT_W  = 16;  // floor(sqrt(2^31 - 1)) fits in 16 bits
    localparam int REM_W   = ROOT_W;
    localparam int CNT_W   = 5;   // counts up to DIV_W - 1

    typedef struct packed {
        logic load_in;    // capture number, set up trivial result and root search
        logic sqrt_step;  // one root bit
        logic res_prime;  // divisor ran down to one: (N, 1)
        logic start_div;  // begin N / b
        logic div_step;   // one quotient bit
        logic res_found;  // exact divisor: (N / b, b)
        logic dec_b;      // next candidate divisor
        logic load_out;   // move result into the output register
    } ffs_cmd_t;

    typedef struct packed {
        logic trivial;    // input is rejected or even, no search needed
        logic cnt_zero;   // last root bit or last quotient bit
        logic b_le1;      // candidate divisor is one
        logic rem_zero;   // division left no remainder
    } ffs_sts_t;

endpackage

// File: sv/fermat_factor_split.sv
// Rejected or even numbers go from the input transaction straight to the done state and m_valid.
// Odd numbers: a 16-bit square root (one bit/cycle), then per candidate divisor a check,
//   a 31-bit restoring division and an evaluate step, then a load into the output register.
// Primes take up to about 46340 candidates; one item in flight at a time.
// Reset: aresetn synchronous, active low; clears controller state and m_valid.
module fermat_factor_split (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ffs_pkg::NUM_W-1:0]      s_number,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ffs_pkg::LARGE_W-1:0]    m_factor_large,
    output logic [ffs_pkg::SMALL_W-1:0]    m_factor_small,
    output logic                           m_rejected
);
    import ffs_pkg::*;

    // Fermat's first hit equals the pair whose small factor is the largest
    // divisor not above floor(sqrt(N)); the datapath finds that divisor by
    // counting down from the root and dividing each candidate.
    ffs_cmd_t cmd;
    ffs_sts_t sts;

    // Sequencer: idle -> root search -> (check -> divide -> evaluate)* -> done; trivial inputs skip to done.
    // The output register lets a new transaction start while a result waits.
    ffs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Shared root/divisor register, bit-serial root and quotient units,
    // result staging and output payload registers.
    ffs_datapath u_datapath (
        .aclk           (aclk),
        .s_number       (s_number),
        .cmd            (cmd),
        .sts            (sts),
        .m_factor_large (m_factor_large),
        .m_factor_small (m_factor_small),
        .m_rejected     (m_rejected)
    );

endmodule

// File: sv/ffs_datapath.sv
module ffs_datapath (
    input  logic                           aclk,
    input  logic [ffs_pkg::NUM_W-1:0]      s_number,
    input  ffs_pkg::ffs_cmd_t              cmd,
    output ffs_pkg::ffs_sts_t              sts,
    output logic [ffs_pkg::LARGE_W-1:0]    m_factor_large,
    output logic [ffs_pkg::SMALL_W-1:0]    m_factor_small,
    output logic                           m_rejected
);
    import ffs_pkg::*;

    logic [DIV_W-1:0]   n_reg;
    logic [ROOT_W-1:0]  root_reg;     // root during search, then divisor candidate b
    logic [CNT_W-1:0]   cnt_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [DIV_W-1:0]   quo_reg;
    logic [LARGE_W-1:0] res_large_reg;
    logic [SMALL_W-1:0] res_small_reg;
    logic               res_rej_reg;
    logic [LARGE_W-1:0] out_large_reg;
    logic [SMALL_W-1:0] out_small_reg;
    logic               out_rej_reg;

    logic               in_rej;
    logic [ROOT_W-1:0]  trial;
    logic [2*ROOT_W-1:0] trial_sq;
    logic [REM_W:0]     rem_sh;
    logic [REM_W:0]     rem_diff;
    logic               div_ge;
    logic [REM_W-1:0]   rem_next;
    logic [DIV_W-1:0]   quo_next;

    assign in_rej = (s_number == '0) || s_number[NUM_W-1];

    // square root: set one bit, keep it if trial^2 still fits
    assign trial    = root_reg | (ROOT_W'(1) << cnt_reg[$clog2(ROOT_W)-1:0]);
    assign trial_sq = (2*ROOT_W)'(trial) * (2*ROOT_W)'(trial);

    // restoring division, one quotient bit per cycle
    assign rem_sh   = {rem_reg, quo_reg[DIV_W-1]};
    assign div_ge   = rem_sh >= {1'b0, root_reg};
    assign rem_diff = rem_sh - {1'b0, root_reg};
    assign rem_next = div_ge ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
    assign quo_next = {quo_reg[DIV_W-2:0], div_ge};

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            n_reg         <= s_number[DIV_W-1:0];
            root_reg      <= '0;
            cnt_reg       <= CNT_W'(ROOT_W - 1);
            res_rej_reg   <= in_rej;
            res_large_reg <= in_rej ? '0 : LARGE_W'(2);
            res_small_reg <= in_rej ? '0 : s_number[SMALL_W:1];
        end
        if (cmd.sqrt_step) begin
            if (trial_sq <= {1'b0, n_reg}) begin
                root_reg <= trial;
            end
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        if (cmd.res_prime) begin
            res_large_reg <= n_reg;
            res_small_reg <= SMALL_W'(1);
        end
        if (cmd.start_div) begin
            rem_reg <= '0;
            quo_reg <= n_reg;
            cnt_reg <= CNT_W'(DIV_W - 1);
        end
        if (cmd.div_step) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        if (cmd.res_found) begin
            res_large_reg <= quo_reg;
            res_small_reg <= SMALL_W'(root_reg);
        end
        if (cmd.dec_b) begin
            root_reg <= root_reg - ROOT_W'(1);
        end
        if (cmd.load_out) begin
            out_large_reg <= res_large_reg;
            out_small_reg <= res_small_reg;
            out_rej_reg   <= res_rej_reg;
        end
    end

    assign sts.trivial  = in_rej || !s_number[0];
    assign sts.cnt_zero = (cnt_reg == '0);
    assign sts.b_le1    = (root_reg <= ROOT_W'(1));
    assign sts.rem_zero = (rem_reg == '0);

    assign m_factor_large = out_large_reg;
    assign m_factor_small = out_small_reg;
    assign m_rejected     = out_rej_reg;

endmodule

// File: sv/ffs_ctrl.sv
`include "fermat_factor_split_defines.svh"

module ffs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  ffs_pkg::ffs_sts_t sts,
    output ffs_pkg::ffs_cmd_t cmd
);
    import ffs_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SQRT  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_EVAL  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = sts.trivial ? ST_DONE : ST_SQRT;
                end
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (sts.cnt_zero) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.b_le1) begin
                    cmd.res_prime = 1'b1;
                    state_next    = ST_DONE;
                end else begin
                    cmd.start_div = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.cnt_zero) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (sts.rem_zero) begin
                    cmd.res_found = 1'b1;
                    state_next    = ST_DONE;
                end else begin
                    cmd.dec_b  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `FFS_ASSERT_NEXT(a_load_sets_valid, aclk, aresetn, (state_reg == ST_DONE) && out_free, m_valid_reg, "result load did not raise m_valid")
    `FFS_ASSERT_NEXT(a_trivial_skips, aclk, aresetn, s_valid && s_ready && sts.trivial, state_reg == ST_DONE, "trivial input did not skip search")
    `FFS_ASSERT_NEXT(a_div_ends, aclk, aresetn, (state_reg == ST_DIV) && sts.cnt_zero, state_reg == ST_EVAL, "division did not end on last bit")
    `FFS_ASSERT_NOW(a_no_overwrite, aclk, aresetn, cmd.load_out, !m_valid_reg || m_ready, "output overwritten before transaction")

endmodule

// File: test/fermat_factor_split_test.sv
`timescale 1ns / 1ps

module fermat_factor_split_test;
    import ffs_pkg::*;

    localparam int RANDOM_NUMBERS = 700;
    localparam int DRAIN_CYCLES   = 50;
    localparam int CYCLE_LIMIT    = 20_000_000;

    typedef struct packed {
        logic [LARGE_W-1:0] hi_factor;
        logic [SMALL_W-1:0] lo_factor;
        logic               rejected;
    } factor_pair_t;

    // known = 1: pair typed in below; known = 0: pair comes from split_number
    typedef struct packed {
        logic [NUM_W-1:0]   number;
        logic               known;
        logic [LARGE_W-1:0] hi_factor;
        logic [SMALL_W-1:0] lo_factor;
        logic               rejected;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 21;
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        // zero and negatives are rejected
        '{32'h0000_0000, 1'b1, 31'd0, 30'd0, 1'b1},
        '{32'h8000_0000, 1'b1, 31'd0, 30'd0, 1'b1},
        '{32'hFFFF_FFFF, 1'b1, 31'd0, 30'd0, 1'b1},
        '{32'hAAAA_AAAA, 1'b1, 31'd0, 30'd0, 1'b1},
        // one is odd and splits as (1, 1)
        '{32'd1,         1'b1, 31'd1, 30'd1, 1'b0},
        // even numbers: (2, N/2)
        '{32'd2,         1'b1, 31'd2, 30'd1, 1'b0},
        '{32'd4,         1'b1, 31'd2, 30'd2, 1'b0},
        '{32'h7FFF_FFFE, 1'b1, 31'd2, 30'h3FFF_FFFF, 1'b0},
        '{32'h5555_5554, 1'b1, 31'd2, 30'h2AAA_AAAA, 1'b0},
        '{32'h4000_0000, 1'b1, 31'd2, 30'h2000_0000, 1'b0},
        // odd primes: (N, 1); 65521 runs the descent from 255 all the way down to 2
        '{32'd3,         1'b1, 31'd3, 30'd1, 1'b0},
        '{32'd97,        1'b1, 31'd97, 30'd1, 1'b0},
        '{32'd65521,     1'b1, 31'd65521, 30'd1, 1'b0},
        // perfect square
        '{32'd9,         1'b1, 31'd3, 30'd3, 1'b0},
        // odd composites
        '{32'd15,        1'b0, 31'd0, 30'd0, 1'b0},
        '{32'd45,        1'b0, 31'd0, 30'd0, 1'b0},
        '{32'd255,       1'b0, 31'd0, 30'd0, 1'b0},
        '{32'd65535,     1'b0, 31'd0, 30'd0, 1'b0},
        '{32'd1000001,   1'b0, 31'd0, 30'd0, 1'b0},
        // root 46339, one below the largest: 46339 * 46341 and 46339^2
        '{32'd2147395599, 1'b0, 31'd0, 30'd0, 1'b0},
        '{32'd2147302921, 1'b0, 31'd0, 30'd0, 1'b0}
    };

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_valid  = 1'b0;
    logic                s_ready;
    logic [NUM_W-1:0]    s_number = '0;
    logic                m_valid;
    logic                m_ready  = 1'b0;
    logic [LARGE_W-1:0]  m_factor_large;
    logic [SMALL_W-1:0]  m_factor_small;
    logic                m_rejected;

    factor_pair_t pending_pairs [$];
    int           error_count   = 0;
    int           cycle_count   = 0;
    int           pairs_checked = 0;
    int           rejected_sent = 0;
    int           even_sent     = 0;
    int           odd_sent      = 0;
    bit           steady        = 1'b0;   // no idling on either side while set

    fermat_factor_split DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_number       (s_number),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_factor_large (m_factor_large),
        .m_factor_small (m_factor_small),
        .m_rejected     (m_rejected)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Largest divisor not above floor(sqrt(N)) gives the Fermat pair.
    function automatic factor_pair_t split_number(input logic [NUM_W-1:0] value);
        factor_pair_t  pair;
        logic [15:0]   root;
        logic [15:0]   trial;
        logic [31:0]   divisor;
        pair = '0;
        if (value == '0 || value[NUM_W-1]) begin
            pair.rejected = 1'b1;
        end else if (!value[0]) begin
            pair.hi_factor = LARGE_W'(2);
            pair.lo_factor = value[SMALL_W:1];
        end else begin
            root = '0;
            for (int bit_idx = 15; bit_idx >= 0; bit_idx--) begin
                trial = root | (16'd1 << bit_idx);
                if ({16'd0, trial} * {16'd0, trial} <= value)
                    root = trial;
            end
            divisor = {16'd0, root};
            while (divisor > 1 && (value % divisor) != 0)
                divisor--;
            if (divisor == 0)
                divisor = 1;
            pair.hi_factor = LARGE_W'(value / divisor);
            pair.lo_factor = divisor[SMALL_W-1:0];
        end
        return pair;
    endfunction

    // Mix of classes; odd numbers are kept cheap for the divisor descent:
    // small odds, or products of two close odd factors whose root lands near a divisor.
    function automatic logic [NUM_W-1:0] draw_number();
        logic [NUM_W-1:0] value;
        longint           lo;
        longint           hi;
        longint           prod;
        int               pick;
        pick  = $urandom_range(0, 99);
        value = $urandom();
        if (pick < 15) begin
            value[NUM_W-1] = 1'b1;
            if (pick == 0)
                value = '0;
        end else if (pick < 45) begin
            value[NUM_W-1] = 1'b0;
            value[0]       = 1'b0;
            if (value == '0)
                value = NUM_W'(2);
        end else if (pick < 80) begin
            if ($urandom_range(0, 9) == 0)
                value = NUM_W'($urandom_range(0, 32767) * 2 + 1);
            else
                value = NUM_W'($urandom_range(0, 2047) * 2 + 1);
        end else begin
            lo   = longint'($urandom_range(1, 23169)) * 2 + 1;
            hi   = lo + 2 * longint'($urandom_range(0, 3));
            prod = lo * hi;
            if (prod > 64'h7FFF_FFFF)
                prod = lo * lo;
            value = NUM_W'(prod);
        end
        return value;
    endfunction

    task automatic send_number(input logic [NUM_W-1:0] value, input logic known,
                               input factor_pair_t typed);
        int gap;
        @(negedge aclk);
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_number <= value;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pending_pairs.push_back(known ? typed : split_number(value));
        if (value == '0 || value[NUM_W-1])
            rejected_sent++;
        else if (!value[0])
            even_sent++;
        else
            odd_sent++;
    endtask

    // Result side: random stall before each transaction, ready held until it lands.
    initial begin : result_sink
        int stall;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            stall = steady ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    always @(posedge aclk) begin
        factor_pair_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pairs.size() == 0) begin
                $error("result transaction with nothing expected: large=%0d small=%0d rej=%0b",
                       m_factor_large, m_factor_small, m_rejected);
                error_count++;
            end else begin
                want = pending_pairs.pop_front();
                pairs_checked++;
                if (m_factor_large !== want.hi_factor) begin
                    $error("factor_large: expected %0d, actual %0d",
                           want.hi_factor, m_factor_large);
                    error_count++;
                end
                if (m_factor_small !== want.lo_factor) begin
                    $error("factor_small: expected %0d, actual %0d",
                           want.lo_factor, m_factor_small);
                    error_count++;
                end
                if (m_rejected !== want.rejected) begin
                    $error("rejected: expected %0b, actual %0b", want.rejected, m_rejected);
                    error_count++;
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        factor_pair_t typed;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        for (int row = 0; row < DIRECTED_ROWS; row++) begin
            typed = '{DIRECTED[row].hi_factor, DIRECTED[row].lo_factor,
                      DIRECTED[row].rejected};
            send_number(DIRECTED[row].number, DIRECTED[row].known, typed);
        end

        // every fourth block of 64 runs back to back on both sides
        for (int item = 0; item < RANDOM_NUMBERS; item++) begin
            steady = ((item / 64) % 4) == 3;
            send_number(draw_number(), 1'b0, '0);
        end
        steady = 1'b0;
        @(negedge aclk);
        s_valid <= 1'b0;

        while (pending_pairs.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d factor pairs: %0d rejected, %0d even, %0d odd by divisor search.",
                 pairs_checked, rejected_sent, even_sent, odd_sent);
        $display("Random idling on both handshakes, with back-to-back stretches; %0d cycles.",
                 cycle_count);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
